// ----- sv/slt_pkg.sv -----
// Shared types, constants and codes for the scoped lease table.
package slt_pkg;

    // Table geometry
    localparam int ENTRIES = 64;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = 7;
    localparam int KEY_W   = 32;
    localparam int TIME_W  = 64;
    localparam int RGT_W   = 3;

    // Rights a lease can hold: read, write, forward
    localparam logic [7:0] RIGHTS_ALL = 8'h07;

    typedef enum logic [2:0] {
        MODE_GRANT   = 3'd0,
        MODE_REVOKE  = 3'd1,
        MODE_CHECK   = 3'd2,
        MODE_RELEASE = 3'd3,
        MODE_REAP    = 3'd4
    } mode_t;

    typedef enum logic [2:0] {
        STAT_OK     = 3'd0,
        STAT_INVAL  = 3'd1,
        STAT_FULL   = 3'd2,
        STAT_NOENT  = 3'd3,
        STAT_DENIED = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } state_t;

    // Input beat
    typedef struct packed {
        logic [2:0]        mode;
        logic [KEY_W-1:0]  session_key;
        logic [KEY_W-1:0]  cred_key;
        logic [7:0]        rights;
        logic [TIME_W-1:0] expiry_time;
        logic [TIME_W-1:0] now_time;
    } lease_req_t;

    // Result beat
    typedef struct packed {
        logic [2:0]       status;
        logic [CNT_W-1:0] removed_count;
        logic [CNT_W-1:0] entry_count;
    } lease_rsp_t;

    // One stored lease
    typedef struct packed {
        logic [KEY_W-1:0]  session;
        logic [KEY_W-1:0]  cred;
        logic [RGT_W-1:0]  rights;
        logic [TIME_W-1:0] expiry;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Compare unit flags for one entry
    typedef struct packed {
        logic sess_eq;
        logic cred_eq;
        logic expired;
        logic rights_ok;
    } cmp_t;

    // Lease memory access from the sequencer
    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        entry_t           wdata;
        logic [IDX_W-1:0] raddr;
    } ram_req_t;

endpackage

// ----- sv/scoped_lease_table.sv -----
// Scoped lease table: top level with lease memory, compare unit and sequencer.
// Each accepted beat scans every slot, one slot per cycle, through the single read
// port of the lease memory before the result strobe rises; an invalid mode or a grant
// with stray rights bits skips the scan. A new beat is taken at the edge that ends
// the result cycle. The receiver cannot stall; reset clears all valid bits and the
// live count at once.
module scoped_lease_table import slt_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  lease_req_t req,
    output logic       done,
    output lease_rsp_t rsp
);

    lease_req_t cur_req;
    cmp_t       flags;
    ram_req_t   ram;
    entry_t     rd_ent;
    logic [ENTRY_W-1:0] rd_data;

    assign rd_ent = entry_t'(rd_data);

    // Lease memory
    slt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (ram.we),
        .waddr (ram.waddr),
        .wdata (ram.wdata),
        .raddr (ram.raddr),
        .rdata (rd_data)
    );

    // Per-entry compare
    slt_cmp u_cmp (
        .ent   (rd_ent),
        .req   (cur_req),
        .flags (flags)
    );

    // Scan sequencer
    slt_seq u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .req     (req),
        .done    (done),
        .rsp     (rsp),
        .cur_req (cur_req),
        .flags   (flags),
        .ram     (ram)
    );

endmodule

// ----- sv/slt_ram.sv -----
// Generic single write, single read RAM with registered read data.
module slt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/slt_cmp.sv -----
// Shared compare unit: tests one stored lease against the current request.
module slt_cmp import slt_pkg::*; (
    input  entry_t     ent,
    input  lease_req_t req,
    output cmp_t       flags
);

    logic [7:0] have;

    assign have = {{(8-RGT_W){1'b0}}, ent.rights};

    // Key matches, expiry test and rights coverage
    always_comb
    begin
        flags.sess_eq   = (ent.session == req.session_key);
        flags.cred_eq   = (ent.cred == req.cred_key);
        flags.expired   = (ent.expiry != '0) && (req.now_time >= ent.expiry);
        flags.rights_ok = ((req.rights & ~have) == 8'h00);
    end

endmodule

// ----- sv/slt_seq.sv -----
// Sequencer: scans the lease memory one slot per cycle and applies the operation.
module slt_seq import slt_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  lease_req_t req,
    output logic       done,
    output lease_rsp_t rsp,
    output lease_req_t cur_req,
    input  cmp_t       flags,
    output ram_req_t   ram
);

    state_t             state_reg, state_next;
    lease_req_t         req_reg, req_next;
    logic [IDX_W:0]     idx_reg, idx_next;
    logic               eval_vld_reg, eval_vld_next;
    logic [IDX_W-1:0]   eval_idx_reg, eval_idx_next;
    logic [ENTRIES-1:0] valid_reg, valid_next;
    logic [CNT_W-1:0]   live_reg, live_next;
    logic [CNT_W-1:0]   removed_reg, removed_next;
    logic               hit_reg, hit_next;
    logic               free_reg, free_next;
    logic [IDX_W-1:0]   slot_reg, slot_next;
    logic [2:0]         chk_stat_reg, chk_stat_next;
    logic               bad_reg, bad_next;
    logic               done_reg, done_next;
    lease_rsp_t         rsp_reg, rsp_next;
    logic               ent_v;
    logic [2:0]         stat;

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            idx_reg      <= '0;
            eval_vld_reg <= 1'b0;
            valid_reg    <= '0;
            live_reg     <= '0;
            removed_reg  <= '0;
            hit_reg      <= 1'b0;
            free_reg     <= 1'b0;
            bad_reg      <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            eval_vld_reg <= eval_vld_next;
            valid_reg    <= valid_next;
            live_reg     <= live_next;
            removed_reg  <= removed_next;
            hit_reg      <= hit_next;
            free_reg     <= free_next;
            bad_reg      <= bad_next;
            done_reg     <= done_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        eval_idx_reg <= eval_idx_next;
        slot_reg     <= slot_next;
        chk_stat_reg <= chk_stat_next;
        rsp_reg      <= rsp_next;
    end

    assign ent_v = valid_reg[eval_idx_reg];

    // Next state, scan evaluation and finish
    always_comb
    begin
        state_next    = state_reg;
        req_next      = req_reg;
        idx_next      = idx_reg;
        eval_vld_next = 1'b0;
        eval_idx_next = eval_idx_reg;
        valid_next    = valid_reg;
        live_next     = live_reg;
        removed_next  = removed_reg;
        hit_next      = hit_reg;
        free_next     = free_reg;
        slot_next     = slot_reg;
        chk_stat_next = chk_stat_reg;
        bad_next      = bad_reg;
        done_next     = 1'b0;
        rsp_next      = rsp_reg;
        stat          = STAT_OK;
        ram.we        = 1'b0;
        ram.waddr     = slot_reg;
        ram.wdata.session = req_reg.session_key;
        ram.wdata.cred    = req_reg.cred_key;
        ram.wdata.rights  = req_reg.rights[RGT_W-1:0];
        ram.wdata.expiry  = req_reg.expiry_time;
        ram.raddr     = idx_reg[IDX_W-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    req_next     = req;
                    idx_next     = '0;
                    removed_next = '0;
                    hit_next     = 1'b0;
                    free_next    = 1'b0;
                    chk_stat_next = STAT_OK;
                    // Unknown modes and grants with stray rights skip the scan
                    bad_next = (req.mode > MODE_REAP) ||
                               ((req.mode == MODE_GRANT) &&
                                ((req.rights & ~RIGHTS_ALL) != 8'h00));
                    state_next = bad_next ? S_FINISH : S_SCAN;
                end
            end

            S_SCAN:
            begin
                // Issue the read for the next slot
                if (idx_reg != ENTRIES[IDX_W:0])
                begin
                    eval_vld_next = 1'b1;
                    eval_idx_next = idx_reg[IDX_W-1:0];
                    idx_next      = idx_reg + 1'b1;
                end
                else
                begin
                    state_next = S_FINISH;
                end

                // Evaluate the slot whose data just came back
                if (eval_vld_reg)
                begin
                    case (req_reg.mode)
                        MODE_GRANT:
                        begin
                            if (!hit_reg)
                            begin
                                if (ent_v && flags.sess_eq && flags.cred_eq)
                                begin
                                    hit_next  = 1'b1;
                                    slot_next = eval_idx_reg;
                                end
                                else if (!ent_v && !free_reg)
                                begin
                                    free_next = 1'b1;
                                    slot_next = eval_idx_reg;
                                end
                            end
                        end
                        MODE_REVOKE:
                        begin
                            if (!hit_reg && ent_v && flags.sess_eq && flags.cred_eq)
                            begin
                                hit_next = 1'b1;
                                valid_next[eval_idx_reg] = 1'b0;
                                live_next = live_reg - 1'b1;
                            end
                        end
                        MODE_CHECK:
                        begin
                            if (!hit_reg && ent_v && flags.cred_eq)
                            begin
                                hit_next = 1'b1;
                                chk_stat_next = (flags.sess_eq && !flags.expired &&
                                                 flags.rights_ok) ? STAT_OK : STAT_DENIED;
                            end
                        end
                        MODE_RELEASE:
                        begin
                            if (ent_v && flags.sess_eq)
                            begin
                                valid_next[eval_idx_reg] = 1'b0;
                                live_next    = live_reg - 1'b1;
                                removed_next = removed_reg + 1'b1;
                            end
                        end
                        MODE_REAP:
                        begin
                            if (ent_v && flags.expired)
                            begin
                                valid_next[eval_idx_reg] = 1'b0;
                                live_next    = live_reg - 1'b1;
                                removed_next = removed_reg + 1'b1;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            S_FINISH:
            begin
                if (bad_reg)
                begin
                    stat = STAT_INVAL;
                end
                else
                begin
                    case (req_reg.mode)
                        MODE_GRANT:
                        begin
                            if (!hit_reg && !free_reg)
                            begin
                                stat = STAT_FULL;
                            end
                            else if ((req_reg.session_key == '0) ||
                                     (req_reg.cred_key == '0))
                            begin
                                stat = STAT_INVAL;
                            end
                            else
                            begin
                                // Store the lease; a fresh slot adds to the count
                                ram.we = 1'b1;
                                if (!hit_reg)
                                begin
                                    valid_next[slot_reg] = 1'b1;
                                    live_next = live_reg + 1'b1;
                                end
                            end
                        end
                        MODE_REVOKE:  stat = hit_reg ? STAT_OK : STAT_NOENT;
                        MODE_CHECK:   stat = hit_reg ? chk_stat_reg : STAT_NOENT;
                        MODE_RELEASE: stat = STAT_OK;
                        MODE_REAP:    stat = STAT_OK;
                        default:      stat = STAT_INVAL;
                    endcase
                end
                rsp_next.status        = stat;
                rsp_next.removed_count = removed_reg;
                rsp_next.entry_count   = live_next;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy    = (state_reg != S_IDLE);
    assign done    = done_reg;
    assign rsp     = rsp_reg;
    assign cur_req = req_reg;

endmodule

// ----- sv/slt_chk.sv -----
// Port-level checker for the scoped lease table, bound to the top level.
module slt_chk import slt_pkg::*; (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       done,
    input lease_rsp_t rsp
);

    // An accepted beat makes the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted beat did not raise busy");

    // Every item ends with exactly one result
    a_fall_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy dropped without a result");

    a_done_once: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for two cycles");

    // Counts stay within the table and removals only come with ok
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (rsp.entry_count <= CNT_W'(ENTRIES)))
        else $error("live count beyond table size");

    a_removed_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (rsp.status != STAT_OK)) |-> (rsp.removed_count == '0))
        else $error("entries removed on a failing operation");

endmodule

bind scoped_lease_table slt_chk u_chk (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done),
    .rsp   (rsp)
);

// ----- bench/scoped_lease_table_test.sv -----
// Self-checking testbench for the scoped lease table: directed, table-full and random lease traffic.
module scoped_lease_table_test;
    import slt_pkg::*;

    // Mode codes the block must reject as invalid
    localparam logic [2:0] MODE_SPARE_A = 3'd5;
    localparam logic [2:0] MODE_SPARE_C = 3'd7;

    localparam logic [KEY_W-1:0]  KEY_MAX  = {KEY_W{1'b1}};
    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 70;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       start;
    logic       busy;
    lease_req_t req;
    logic       done;
    lease_rsp_t rsp;

    scoped_lease_table i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    always #5 clk = ~clk;

    // Shadow copy of the lease table
    logic              tbl_valid  [ENTRIES];
    logic [KEY_W-1:0]  tbl_sess   [ENTRIES];
    logic [KEY_W-1:0]  tbl_cred   [ENTRIES];
    logic [RGT_W-1:0]  tbl_rights [ENTRIES];
    logic [TIME_W-1:0] tbl_expiry [ENTRIES];
    int                tbl_live;

    // Results owed by the block, oldest first
    lease_rsp_t lease_rsp_q [$];

    int errors = 0;
    int rsp_beats = 0;
    int stat_seen [8];
    int removed_peak = 0;
    int cycles = 0;

    // Sender idling
    bit idle_on = 1'b0;
    int burst_left = 0;

    // Time base that drifts forward so leases expire during the run
    logic [TIME_W-1:0] tbase;

    // Apply one operation to the shadow table and return the owed result
    function automatic lease_rsp_t apply_lease_op(lease_req_t r);
        lease_rsp_t o;
        int i;
        int slot;
        int removed;
        logic [7:0] held;
        o.status = STAT_OK;
        slot = -1;
        removed = 0;
        case (r.mode)
            MODE_GRANT:
            begin
                if ((r.rights & ~RIGHTS_ALL) != 8'd0)
                    o.status = STAT_INVAL;
                else
                begin
                    // exact match wins, else lowest free slot
                    for (i = 0; i < ENTRIES; i++)
                    begin
                        if (!tbl_valid[i])
                        begin
                            if (slot < 0)
                                slot = i;
                        end
                        else if (tbl_sess[i] == r.session_key && tbl_cred[i] == r.cred_key)
                        begin
                            slot = i;
                            break;
                        end
                    end
                    if (slot < 0)
                        o.status = STAT_FULL;
                    else if (r.session_key == '0 || r.cred_key == '0)
                        o.status = STAT_INVAL;
                    else
                    begin
                        if (!tbl_valid[slot])
                            tbl_live++;
                        tbl_valid[slot]  = 1'b1;
                        tbl_sess[slot]   = r.session_key;
                        tbl_cred[slot]   = r.cred_key;
                        tbl_rights[slot] = r.rights[RGT_W-1:0];
                        tbl_expiry[slot] = r.expiry_time;
                    end
                end
            end
            MODE_REVOKE:
            begin
                o.status = STAT_NOENT;
                for (i = 0; i < ENTRIES; i++)
                begin
                    if (tbl_valid[i] && tbl_sess[i] == r.session_key
                        && tbl_cred[i] == r.cred_key)
                    begin
                        tbl_valid[i] = 1'b0;
                        tbl_live--;
                        o.status = STAT_OK;
                        break;
                    end
                end
            end
            MODE_CHECK:
            begin
                o.status = STAT_NOENT;
                for (i = 0; i < ENTRIES; i++)
                begin
                    if (tbl_valid[i] && tbl_cred[i] == r.cred_key)
                    begin
                        slot = i;
                        break;
                    end
                end
                if (slot >= 0)
                begin
                    // wanted bits above forward can never be held
                    held = {5'd0, tbl_rights[slot]};
                    if (tbl_sess[slot] != r.session_key)
                        o.status = STAT_DENIED;
                    else if (tbl_expiry[slot] != '0 && r.now_time >= tbl_expiry[slot])
                        o.status = STAT_DENIED;
                    else if ((held & r.rights) != r.rights)
                        o.status = STAT_DENIED;
                    else
                        o.status = STAT_OK;
                end
            end
            MODE_RELEASE:
            begin
                for (i = 0; i < ENTRIES; i++)
                begin
                    if (tbl_valid[i] && tbl_sess[i] == r.session_key)
                    begin
                        tbl_valid[i] = 1'b0;
                        tbl_live--;
                        removed++;
                    end
                end
            end
            MODE_REAP:
            begin
                for (i = 0; i < ENTRIES; i++)
                begin
                    if (tbl_valid[i] && tbl_expiry[i] != '0 && r.now_time >= tbl_expiry[i])
                    begin
                        tbl_valid[i] = 1'b0;
                        tbl_live--;
                        removed++;
                    end
                end
            end
            default:
                o.status = STAT_INVAL;
        endcase
        o.removed_count = CNT_W'(removed);
        o.entry_count   = CNT_W'(tbl_live);
        return o;
    endfunction

    function automatic lease_req_t mk_lease(logic [2:0] m, logic [KEY_W-1:0] s,
                                            logic [KEY_W-1:0] c, logic [7:0] rg,
                                            logic [TIME_W-1:0] ex, logic [TIME_W-1:0] nw);
        lease_req_t r;
        r.mode        = m;
        r.session_key = s;
        r.cred_key    = c;
        r.rights      = rg;
        r.expiry_time = ex;
        r.now_time    = nw;
        return r;
    endfunction

    // Send one request beat; entered and left at a rising edge
    task automatic send_lease(input lease_req_t r);
        int gap;
        if (idle_on && burst_left == 0)
        begin
            burst_left = $urandom_range(1, 10);
            gap = $urandom_range(1, 75);
            start <= 1'b0;
            req <= mk_lease(3'($urandom), $urandom, $urandom, 8'($urandom),
                            {$urandom, $urandom}, {$urandom, $urandom});
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        req <= r;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        lease_rsp_q.push_back(apply_lease_op(r));
        if (burst_left > 0)
            burst_left--;
    endtask

    // Hold off until every owed result has arrived
    task automatic wait_drained();
        start <= 1'b0;
        do
            @(posedge clk);
        while (lease_rsp_q.size() != 0);
    endtask

    // Extremes, every mode and each corner of grant, check and the empty key
    task automatic test_directed();
        send_lease(mk_lease(MODE_CHECK, 1, 10, 8'd1, 0, 0));        // empty table
        send_lease(mk_lease(MODE_REVOKE, 1, 10, 8'd0, 0, 0));
        send_lease(mk_lease(MODE_GRANT, 1, 10, 8'd7, 0, 0));
        send_lease(mk_lease(MODE_GRANT, 1, 11, 8'h80, 0, 0));       // stray rights bit
        send_lease(mk_lease(MODE_GRANT, 0, 11, 8'd1, 0, 0));        // empty session
        send_lease(mk_lease(MODE_GRANT, 4, 0, 8'd1, 0, 0));         // empty credential
        send_lease(mk_lease(MODE_GRANT, 1, 10, 8'd1, 1000, 0));     // update in place
        send_lease(mk_lease(MODE_GRANT, 2, 10, 8'd3, 0, 0));
        send_lease(mk_lease(MODE_CHECK, 1, 10, 8'd1, 0, 999));
        send_lease(mk_lease(MODE_CHECK, 1, 10, 8'd1, 0, 1000));     // expires exactly now
        send_lease(mk_lease(MODE_CHECK, 1, 10, 8'd2, 0, 0));        // missing right
        send_lease(mk_lease(MODE_CHECK, 2, 10, 8'd1, 0, 0));        // first holder differs
        send_lease(mk_lease(MODE_GRANT, 3, 20, 8'd7, 0, 0));
        send_lease(mk_lease(MODE_CHECK, 3, 20, 8'h0F, 0, 0));       // wanted bit above forward
        send_lease(mk_lease(MODE_CHECK, 3, 20, 8'd0, 0, TIME_MAX));
        send_lease(mk_lease(MODE_CHECK, 0, 0, 8'd0, 0, 0));
        send_lease(mk_lease(MODE_REVOKE, 0, 0, 8'd0, 0, 0));
        send_lease(mk_lease(MODE_RELEASE, 0, 0, 8'd0, 0, 0));
        send_lease(mk_lease(MODE_GRANT, KEY_MAX, KEY_MAX, 8'd0, TIME_MAX, 0));
        send_lease(mk_lease(MODE_CHECK, KEY_MAX, KEY_MAX, 8'd0, 0, TIME_MAX));
        send_lease(mk_lease(MODE_CHECK, KEY_MAX, KEY_MAX, 8'd0, 0, TIME_MAX - 1));
        send_lease(mk_lease(MODE_REAP, 0, 0, 8'd0, 0, 1000));
        send_lease(mk_lease(MODE_SPARE_A, KEY_MAX, KEY_MAX, 8'hFF, TIME_MAX, TIME_MAX));
        send_lease(mk_lease(MODE_SPARE_C, 1, 10, 8'd7, 0, 0));
        send_lease(mk_lease(MODE_RELEASE, 2, 0, 8'd0, 0, 0));
        send_lease(mk_lease(MODE_REVOKE, KEY_MAX, KEY_MAX, 8'd0, 0, 0));
    endtask

    // Random traffic on a small key pool so grants, checks and revokes collide
    task automatic test_random_mix(input int n_items);
        int k;
        int pick;
        logic [2:0]        m;
        logic [KEY_W-1:0]  s;
        logic [KEY_W-1:0]  c;
        logic [7:0]        rg;
        logic [TIME_W-1:0] ex;
        logic [TIME_W-1:0] nw;
        for (k = 0; k < n_items; k++)
        begin
            // switch between bursty and back-to-back stretches
            if (k % 100 == 0)
            begin
                idle_on = ($urandom_range(0, 3) != 0);
                burst_left = 0;
            end
            tbase = tbase + $urandom_range(0, 4);
            pick = $urandom_range(0, 99);
            if (pick < 38)
                m = MODE_GRANT;
            else if (pick < 60)
                m = MODE_CHECK;
            else if (pick < 74)
                m = MODE_REVOKE;
            else if (pick < 80)
                m = MODE_RELEASE;
            else if (pick < 90)
                m = MODE_REAP;
            else
                m = 3'($urandom_range(MODE_SPARE_A, MODE_SPARE_C));

            pick = $urandom_range(0, 99);
            s = (pick < 80) ? KEY_W'($urandom_range(1, 6)) : (pick < 88) ? '0 : $urandom;
            pick = $urandom_range(0, 99);
            c = (pick < 80) ? KEY_W'($urandom_range(1, 20)) : (pick < 88) ? '0 : $urandom;
            rg = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, 7)) : 8'($urandom);

            pick = $urandom_range(0, 99);
            if (pick < 40)
                ex = '0;
            else if (pick < 85)
                ex = tbase + $urandom_range(1, 200);
            else
                ex = {$urandom, $urandom};
            nw = ($urandom_range(0, 99) < 85) ? tbase + $urandom_range(0, 200)
                                              : {$urandom, $urandom};
            send_lease(mk_lease(m, s, c, rg, ex, nw));
        end
    endtask

    // Fill every slot, push on a full table, then sweep it with release and reap
    task automatic test_full_table();
        int i;
        int found;
        int round;
        logic [KEY_W-1:0] bulk_sess;
        logic [KEY_W-1:0] cred_next;
        logic [TIME_W-1:0] ex;
        idle_on = 1'b1;
        burst_left = 0;
        // empty the table one session at a time
        while (tbl_live != 0)
        begin
            found = -1;
            for (i = 0; i < ENTRIES && found < 0; i++)
                if (tbl_valid[i])
                    found = i;
            send_lease(mk_lease(MODE_RELEASE, tbl_sess[found], 0, 8'd0, 0, 0));
        end
        bulk_sess = $urandom_range(32'h100, 32'hFFFF_FF00);
        cred_next = 32'h4000_0000 + $urandom_range(0, 1000);
        for (round = 0; round < 2; round++)
        begin
            while (tbl_live < ENTRIES)
            begin
                ex = (round == 0 || $urandom_range(0, 1) == 0) ? '0
                                                                : tbase + $urandom_range(1, 500);
                send_lease(mk_lease(MODE_GRANT, bulk_sess, cred_next, 8'($urandom_range(0, 7)),
                                    ex, 0));
                cred_next++;
            end
            send_lease(mk_lease(MODE_GRANT, bulk_sess, cred_next, 8'd7, 0, 0));
            send_lease(mk_lease(MODE_GRANT, 0, cred_next, 8'd7, 0, 0));   // full wins over empty key
            send_lease(mk_lease(MODE_GRANT, bulk_sess, cred_next, 8'h10, 0, 0));
            send_lease(mk_lease(MODE_GRANT, bulk_sess, cred_next - 1, 8'd7, 0, 0));
            for (i = 0; i < 4; i++)
                send_lease(mk_lease(MODE_CHECK, bulk_sess, cred_next - $urandom_range(1, ENTRIES),
                                    8'($urandom_range(0, 7)), 0, tbase + $urandom_range(0, 500)));
            if (round == 1)
                send_lease(mk_lease(MODE_REAP, 0, 0, 8'd0, 0, TIME_MAX));
            send_lease(mk_lease(MODE_RELEASE, bulk_sess, 0, 8'd0, 0, 0));
        end
    endtask

    // Compare each result beat with the oldest owed result
    always @(posedge clk)
    begin
        lease_rsp_t owed;
        if (rst_n && done)
        begin
            rsp_beats++;
            if (lease_rsp_q.size() == 0)
            begin
                $error("result beat with nothing owed: status %0d removed %0d count %0d",
                       rsp.status, rsp.removed_count, rsp.entry_count);
                errors++;
            end
            else
            begin
                owed = lease_rsp_q.pop_front();
                if (rsp.status !== owed.status)
                begin
                    $error("status: expected %0d, got %0d", owed.status, rsp.status);
                    errors++;
                end
                if (rsp.removed_count !== owed.removed_count)
                begin
                    $error("removed_count: expected %0d, got %0d",
                           owed.removed_count, rsp.removed_count);
                    errors++;
                end
                if (rsp.entry_count !== owed.entry_count)
                begin
                    $error("entry_count: expected %0d, got %0d",
                           owed.entry_count, rsp.entry_count);
                    errors++;
                end
                stat_seen[owed.status]++;
                if (owed.removed_count > removed_peak)
                    removed_peak = owed.removed_count;
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("scoped_lease_table_test: FAIL");
            $finish;
        end
    end

    initial
    begin
        int i;
        rst_n = 1'b0;
        start = 1'b0;
        req = '0;
        for (i = 0; i < ENTRIES; i++)
            tbl_valid[i] = 1'b0;
        for (i = 0; i < 8; i++)
            stat_seen[i] = 0;
        tbl_live = 0;
        tbase = {1'b0, 31'($urandom), $urandom};
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_mix(300);
        wait_drained();
        test_full_table();
        test_random_mix(300);

        // let the last beats and any stray strobe show
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("lease table run: %0d results; ok %0d, invalid %0d, full %0d, no entry %0d, denied %0d",
                 rsp_beats, stat_seen[STAT_OK], stat_seen[STAT_INVAL], stat_seen[STAT_FULL],
                 stat_seen[STAT_NOENT], stat_seen[STAT_DENIED]);
        $display("largest single sweep cleared %0d leases; %0d mismatches", removed_peak, errors);
        if (errors == 0 && lease_rsp_q.size() == 0)
            $display("scoped_lease_table_test: PASS");
        else
            $display("scoped_lease_table_test: FAIL");
        $finish;
    end

endmodule

// ----- scoped_lease_table.f -----
sv/slt_pkg.sv
sv/slt_ram.sv
sv/slt_cmp.sv
sv/slt_seq.sv
sv/scoped_lease_table.sv
sv/slt_chk.sv
bench/scoped_lease_table_test.sv
